// File: rtl/bsm_pkg.sv
// Shared types and codes of the bytecode stack machine.
package bsm_pkg;

    localparam int STACK_DEPTH_DEF = 256;

    localparam logic [7:0] OPC_PUSH    = 8'h01;
    localparam logic [7:0] OPC_ADD     = 8'h02;
    localparam logic [7:0] OPC_SUB     = 8'h03;
    localparam logic [7:0] OPC_PRINT   = 8'h04;
    localparam logic [7:0] OPC_ALLOC   = 8'h0B;
    localparam logic [7:0] OPC_SYSCALL = 8'h0C;
    localparam logic [7:0] SYS_HALT    = 8'h24;

    localparam logic [63:0] BUMP_START_RST = 64'd0;

    typedef enum logic [1:0] {
        PH_OPCODE = 2'd0,
        PH_PUSH   = 2'd1,
        PH_ALLOC  = 2'd2,
        PH_SYS    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PRINT = 2'd0,
        KIND_HALT  = 2'd1,
        KIND_END   = 2'd2,
        KIND_FAULT = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic        last;
    } t_result;

endpackage

// File: rtl/bsm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bsm_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bytecode_stack_machine_unit.sv
// Top level of the bytecode stack machine: decoder, value stack and result queue.
//
// The unit takes a bytecode program one byte per item and runs a stack machine on 64-bit
// values, giving print, halt, end-of-code and fault results. An accepted byte is held in
// an input register, decoded and executed there once the result queue has room, and its
// results (at most two) are written into a four-entry result queue, from which they are
// offered to the consumer. A new byte can be accepted in every cycle: the input stalls only
// while a byte waits in the input register and the result queue has fewer than two free
// entries, which happens when the consumer stalls or when bytes that each give two results
// arrive back to back. The top two stack entries live in registers and the rest in a RAM
// whose registered read port always prefetches the third entry from the top, so add,
// subtract and print need no wait on a RAM read; a write bypass covers a push that lands on
// the prefetched address. The stack RAM has no reset and needs no clearing pass, since only
// entries already written are ever read. Writing the start-address register loads the
// bump pointer and should be done only while the unit is idle.
module bytecode_stack_machine_unit #(
    parameter int STACK_DEPTH = bsm_pkg::STACK_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [63:0]         i_cfg_wdata,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_code_byte,
    input  logic                i_end_of_code,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_kind,
    output logic signed [63:0]  o_value,
    output logic                o_last
);

    import bsm_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] C_ONE   = CW'(1);
    localparam logic [CW-1:0] C_TWO   = CW'(2);
    localparam logic [CW-1:0] C_THREE = CW'(3);

    // Input register.
    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_end;

    // Decoder and machine state.
    t_phase      r_phase, n_phase;
    logic [3:0]  r_left, n_left;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_heap, n_heap;
    logic        r_halted, n_halted;
    logic [CW-1:0] r_count, n_count;
    logic [63:0] r_tos, n_tos;
    logic [63:0] r_nos, n_nos;

    // Stack RAM and its bypass.
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, ram_rdata;
    logic [CW-1:0] waddr_full, raddr_full;
    logic          r_byp;
    logic [63:0]   r_byp_data;
    logic [63:0]   below;

    // Result queue.
    t_result     r_fifo [4];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_fcnt;
    logic        fifo_pop;
    logic [1:0]  res_n;
    t_result     slot0, slot1;

    // Decode of the byte in the input register.
    logic        proc, live, halt_now, end_res;
    logic [3:0]  total, left_n, pos, left_dec;
    logic        opnd_done;
    logic [63:0] acc_ins;
    logic        push_req, pop_req, fault;
    logic [63:0] push_val;
    logic        res_a_v;
    t_kind       res_a_kind;
    logic [63:0] res_a_value;

    bsm_ram #(
        .WIDTH (64),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The byte in the input register is executed once the queue can take two results.
    assign proc       = r_in_valid && (r_fcnt <= 3'd2);
    assign live       = proc && !r_halted;
    assign o_stall    = r_in_valid && !proc;
    assign n_in_valid = (i_valid && !o_stall) || (r_in_valid && !proc);

    assign halt_now = live && (r_phase == PH_SYS) && (r_in_byte == SYS_HALT);
    assign end_res  = live && r_in_end && !halt_now;

    // Operand byte position, normalised so that a stray count still lands in range.
    assign total     = (r_phase == PH_PUSH) ? 4'd8 : 4'd4;
    assign left_n    = ((r_left == 4'd0) || (r_left > total)) ? total : r_left;
    assign pos       = total - left_n;
    assign left_dec  = left_n - 4'd1;
    assign opnd_done = (left_dec == 4'd0);
    assign acc_ins   = r_acc | ({56'd0, r_in_byte} << {pos[2:0], 3'b000});

    // The third entry from the top comes from the RAM prefetch or from the bypass.
    assign below = r_byp ? r_byp_data : ram_rdata;

    // Decode phase sequencing.
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        if (live) begin
            unique case (r_phase)
                PH_OPCODE: begin
                    if (r_in_byte == OPC_PUSH) begin
                        n_phase = PH_PUSH;
                        n_left  = 4'd8;
                    end else if (r_in_byte == OPC_ALLOC) begin
                        n_phase = PH_ALLOC;
                        n_left  = 4'd4;
                    end else if (r_in_byte == OPC_SYSCALL) begin
                        n_phase = PH_SYS;
                    end
                end
                PH_PUSH, PH_ALLOC: begin
                    n_left = left_dec;
                    if (opnd_done) begin
                        n_phase = PH_OPCODE;
                    end
                end
                PH_SYS: begin
                    n_phase = PH_OPCODE;
                end
            endcase
            if (end_res) begin
                n_phase = PH_OPCODE;
                n_left  = 4'd0;
            end
        end
    end

    // Execution: stack operations, accumulator, bump pointer and the first result.
    always_comb begin
        n_acc       = r_acc;
        n_heap      = r_heap;
        n_halted    = r_halted;
        push_req    = 1'b0;
        pop_req     = 1'b0;
        push_val    = r_acc;
        fault       = 1'b0;
        res_a_v     = 1'b0;
        res_a_kind  = KIND_PRINT;
        res_a_value = 64'd0;
        n_tos       = r_tos;
        n_nos       = r_nos;
        n_count     = r_count;
        ram_we      = 1'b0;
        waddr_full  = r_count - C_TWO;
        ram_wdata   = r_nos;

        if (live) begin
            unique case (r_phase)
                PH_OPCODE: begin
                    if ((r_in_byte == OPC_PUSH) || (r_in_byte == OPC_ALLOC)) begin
                        n_acc = 64'd0;
                    end else if ((r_in_byte == OPC_ADD) || (r_in_byte == OPC_SUB)) begin
                        if (r_count < C_TWO) begin
                            fault = 1'b1;
                        end else begin
                            pop_req = 1'b1;
                            n_tos   = (r_in_byte == OPC_SUB) ? (r_nos - r_tos)
                                                             : (r_nos + r_tos);
                        end
                    end else if (r_in_byte == OPC_PRINT) begin
                        if (r_count == '0) begin
                            fault = 1'b1;
                        end else begin
                            pop_req     = 1'b1;
                            n_tos       = r_nos;
                            res_a_v     = 1'b1;
                            res_a_kind  = KIND_PRINT;
                            res_a_value = r_tos;
                        end
                    end
                end
                PH_PUSH, PH_ALLOC: begin
                    n_acc = acc_ins;
                    if (opnd_done) begin
                        n_acc = 64'd0;
                        if (r_count >= DEPTH_C) begin
                            fault = 1'b1;
                        end else begin
                            push_req = 1'b1;
                            if (r_phase == PH_PUSH) begin
                                push_val = acc_ins;
                            end else begin
                                push_val = r_heap;
                                n_heap   = r_heap + acc_ins;
                            end
                        end
                    end
                end
                PH_SYS: begin
                    if (halt_now) begin
                        n_halted    = 1'b1;
                        res_a_v     = 1'b1;
                        res_a_kind  = KIND_HALT;
                    end
                end
            endcase

            if (fault) begin
                res_a_v    = 1'b1;
                res_a_kind = KIND_FAULT;
            end
            if (end_res) begin
                n_acc = 64'd0;
            end
        end

        // A push spills the second entry into the RAM; a pop refills it from the prefetch.
        if (push_req) begin
            ram_we  = (r_count >= C_TWO);
            n_nos   = r_tos;
            n_tos   = push_val;
            n_count = r_count + C_ONE;
        end else if (pop_req) begin
            n_nos   = below;
            n_count = r_count - C_ONE;
        end

        if (i_cfg_we) begin
            n_heap = i_cfg_wdata;
        end
    end

    assign raddr_full = n_count - C_THREE;
    assign ram_raddr  = raddr_full[AW-1:0];
    assign ram_waddr  = waddr_full[AW-1:0];

    // Results of this byte: first the print, fault or halt, then end of code.
    always_comb begin
        slot1.kind  = KIND_END;
        slot1.value = 64'd0;
        slot1.last  = 1'b1;
        if (res_a_v) begin
            slot0.kind  = res_a_kind;
            slot0.value = res_a_value;
            slot0.last  = !end_res;
        end else begin
            slot0 = slot1;
        end
        res_n = {1'b0, res_a_v} + {1'b0, end_res};
    end

    assign fifo_pop = o_valid && !i_stall;
    assign o_valid  = (r_fcnt != 3'd0);
    assign o_kind   = r_fifo[r_rp].kind;
    assign o_value  = $signed(r_fifo[r_rp].value);
    assign o_last   = r_fifo[r_rp].last;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_OPCODE;
            r_left     <= 4'd0;
            r_acc      <= 64'd0;
            r_heap     <= BUMP_START_RST;
            r_halted   <= 1'b0;
            r_count    <= '0;
            r_byp      <= 1'b0;
            r_wp       <= 2'd0;
            r_rp       <= 2'd0;
            r_fcnt     <= 3'd0;
        end else begin
            r_in_valid <= n_in_valid;
            r_phase    <= n_phase;
            r_left     <= n_left;
            r_acc      <= n_acc;
            r_heap     <= n_heap;
            r_halted   <= n_halted;
            r_count    <= n_count;
            r_byp      <= ram_we && (ram_waddr == ram_raddr);
            r_wp       <= r_wp + res_n;
            r_rp       <= r_rp + {1'b0, fifo_pop};
            r_fcnt     <= r_fcnt + {1'b0, res_n} - {2'b00, fifo_pop};
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_code_byte;
            r_in_end  <= i_end_of_code;
        end
        r_tos      <= n_tos;
        r_nos      <= n_nos;
        r_byp_data <= ram_wdata;
        if (res_n != 2'd0) begin
            r_fifo[r_wp] <= slot0;
        end
        if (res_n == 2'd2) begin
            r_fifo[r_wp + 2'd1] <= slot1;
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench of the bytecode stack machine unit.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bsm_pkg::*;

    localparam int DEPTH = STACK_DEPTH_DEF;

    // Every input of the unit starts from a known value; reset is held low from time zero.
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [63:0]        i_cfg_wdata = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_code_byte = '0;
    logic               i_end_of_code = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_kind;
    logic signed [63:0] o_value;
    logic               o_last;

    bytecode_stack_machine_unit #(
        .STACK_DEPTH(DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_code_byte   (i_code_byte),
        .i_end_of_code (i_end_of_code),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_value       (o_value),
        .o_last        (o_last)
    );

    // The clock toggles every half period of 4 ns, giving an 8 ns period.
    always #4 i_clk = ~i_clk;

    // Percentages of cycles in which the byte sender holds back and the result
    // receiver stalls. The test tasks change them between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // The receiver draws a fresh stall decision at every edge, so stalls land on
    // every phase of the unit's work and not only at item boundaries.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Our own copy of the machine: value stack, decoder and bump pointer.
    logic [63:0]  stack_mem [DEPTH];
    int unsigned  depth_now;
    t_phase       phase_now;
    logic [3:0]   operand_left;
    logic [63:0]  operand_acc;
    logic [63:0]  bump_ptr;
    bit           is_halted;

    // Results the machine is still owed, oldest first.
    t_result      awaited [$];

    int unsigned  bytes_sent = 0;
    int unsigned  mismatches = 0;

    // A syscall byte of 0x24 would halt the unit for good, and only reset leaves
    // that state, so it is let through only in the very last test.
    bit           halt_enabled = 1'b0;

    function automatic void reset_machine();
        depth_now    = 0;
        phase_now    = PH_OPCODE;
        operand_left = '0;
        operand_acc  = '0;
        bump_ptr     = BUMP_START_RST;
        is_halted    = 1'b0;
        awaited.delete();
    endfunction

    // Runs one accepted byte through the machine and queues the results it causes:
    // at most one print, fault or halt, and then an end-of-code mark.
    function automatic void execute_byte(logic [7:0] b, logic eoc);
        t_result     res [2];
        int          n;
        int unsigned total;
        int unsigned left;
        int unsigned pos;
        logic [63:0] x;
        logic [63:0] y;
        n = 0;
        if (is_halted) return;
        case (phase_now)
            PH_OPCODE: begin
                if (b == OPC_PUSH) begin
                    phase_now    = PH_PUSH;
                    operand_left = 4'd8;
                    operand_acc  = '0;
                end else if (b == OPC_ALLOC) begin
                    phase_now    = PH_ALLOC;
                    operand_left = 4'd4;
                    operand_acc  = '0;
                end else if (b == OPC_SYSCALL) begin
                    phase_now = PH_SYS;
                end else if (b == OPC_ADD || b == OPC_SUB) begin
                    if (depth_now < 2) begin
                        res[n] = '{kind: KIND_FAULT, value: 64'd0, last: 1'b0};
                        n++;
                    end else begin
                        y = stack_mem[depth_now - 1];
                        x = stack_mem[depth_now - 2];
                        depth_now--;
                        stack_mem[depth_now - 1] = (b == OPC_ADD) ? x + y : x - y;
                    end
                end else if (b == OPC_PRINT) begin
                    if (depth_now < 1) begin
                        res[n] = '{kind: KIND_FAULT, value: 64'd0, last: 1'b0};
                    end else begin
                        depth_now--;
                        res[n] = '{kind: KIND_PRINT, value: stack_mem[depth_now], last: 1'b0};
                    end
                    n++;
                end
            end
            PH_PUSH, PH_ALLOC: begin
                total = (phase_now == PH_PUSH) ? 8 : 4;
                left  = operand_left;
                if (left == 0 || left > total) left = total;
                pos = total - left;
                operand_acc = operand_acc | (64'(b) << (8 * pos));
                left--;
                operand_left = 4'(left);
                if (left == 0) begin
                    if (depth_now >= DEPTH) begin
                        // Overflow: the push or alloc is dropped, pointer untouched.
                        res[n] = '{kind: KIND_FAULT, value: 64'd0, last: 1'b0};
                        n++;
                    end else if (phase_now == PH_PUSH) begin
                        stack_mem[depth_now] = operand_acc;
                        depth_now++;
                    end else begin
                        stack_mem[depth_now] = bump_ptr;
                        depth_now++;
                        bump_ptr = bump_ptr + operand_acc;
                    end
                    phase_now   = PH_OPCODE;
                    operand_acc = '0;
                end
            end
            default: begin
                phase_now = PH_OPCODE;
                if (b == SYS_HALT) begin
                    // A halt swallows any end-of-code mark on the same byte.
                    is_halted = 1'b1;
                    awaited.push_back('{kind: KIND_HALT, value: 64'd0, last: 1'b1});
                    return;
                end
            end
        endcase
        if (eoc) begin
            phase_now    = PH_OPCODE;
            operand_left = '0;
            operand_acc  = '0;
            res[n] = '{kind: KIND_END, value: 64'd0, last: 1'b0};
            n++;
        end
        for (int i = 0; i < n; i++) begin
            res[i].last = (i == n - 1);
            awaited.push_back(res[i]);
        end
    endfunction

    // Compares one accepted result with the oldest one owed.
    function automatic void check_result();
        t_result want;
        if (awaited.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected result: kind %0d value %h last %b",
                         o_kind, o_value, o_last);
            mismatches++;
        end else begin
            want = awaited.pop_front();
            if (o_kind !== want.kind || o_value !== want.value || o_last !== want.last) begin
                if (mismatches < 10)
                    $display("mismatch: expected kind %0d value %h last %b, got kind %0d value %h last %b",
                             want.kind, want.value, want.last, o_kind, o_value, o_last);
                mismatches++;
            end
        end
    endfunction

    // Values are sampled at the edge, before the unit's own updates for that edge land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) check_result();
    end

    function automatic bit chance(int pct);
        return ($urandom_range(99) < pct);
    endfunction

    // Offers one byte and returns at the edge where the unit takes it. The valid is
    // left high on return, so that a following item is presented without a dip.
    task automatic send_byte(input logic [7:0] code, input logic eoc);
        logic [7:0] b;
        b = code;
        if (!halt_enabled && phase_now == PH_SYS && b == SYS_HALT) b = code ^ 8'h01;
        while (chance(send_idle_pct)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_code_byte   <= b;
        i_end_of_code <= eoc;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
        execute_byte(b, eoc);
    endtask

    // Operand bytes go out least significant first; each may carry an early end mark.
    task automatic send_operand(input logic [63:0] word, input int nbytes, input int end_pct);
        for (int i = 0; i < nbytes; i++) send_byte(word[8*i +: 8], chance(end_pct));
    endtask

    // Lowers valid and waits until every owed result is in, then waits on so that a byte
    // that causes no result clears the pipeline. Bounded so a lost result shows as a
    // leftover rather than a hang.
    task automatic wait_idle();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (awaited.size() != 0 && guard < 4000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_bump_start(input logic [63:0] start);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= start;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        bump_ptr    = start;
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(6))
            0:       return 64'd0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h7FFF_FFFF_FFFF_FFFF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // A short hand-written program: faults on an empty and a one-entry stack, an
    // alloc with the largest size, a push of all ones, an add, a print that also
    // ends the program, an unknown syscall, an unknown opcode and a cut-off alloc.
    task automatic test_directed_ops();
        send_idle_pct = 30;
        recv_idle_pct = 46;
        send_byte(OPC_PRINT, 1'b0);
        send_byte(OPC_ADD, 1'b0);
        send_byte(OPC_ALLOC, 1'b0);
        send_operand(64'hFFFF_FFFF, 4, 0);
        send_byte(OPC_SUB, 1'b0);
        send_byte(OPC_PUSH, 1'b0);
        send_operand('1, 8, 0);
        send_byte(OPC_ADD, 1'b0);
        send_byte(OPC_PRINT, 1'b1);
        send_byte(OPC_SYSCALL, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h0E, 1'b0);
        send_byte(OPC_ALLOC, 1'b0);
        send_byte(8'h10, 1'b1);
    endtask

    // Mostly well-formed instructions with random operands, the stack depth steered
    // so that both faults and real arithmetic happen, mixed with stray bytes and
    // end marks that cut instructions short.
    task automatic test_random_programs(input int send_pct, input int recv_pct,
                                        input logic [63:0] base, input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned pick;
        logic [63:0] word;
        logic [7:0]  op;
        write_bump_start(base);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if (chance(8)) begin
                send_byte(8'($urandom_range(255)), chance(10));
            end else begin
                pick = $urandom_range(99);
                if (depth_now < 2 && chance(50)) pick = 0;
                if (pick < 30 && depth_now > 40) pick = 70;
                if (pick < 30) begin
                    word = pick_word();
                    send_byte(OPC_PUSH, chance(2));
                    send_operand(word, 8, 3);
                end else if (pick < 40) begin
                    word = chance(25) ? 64'($urandom) : 64'($urandom_range(64));
                    send_byte(OPC_ALLOC, chance(2));
                    send_operand(word, 4, 3);
                end else if (pick < 55) begin
                    send_byte(OPC_ADD, chance(4));
                end else if (pick < 67) begin
                    send_byte(OPC_SUB, chance(4));
                end else if (pick < 85) begin
                    send_byte(OPC_PRINT, chance(5));
                end else if (pick < 90) begin
                    do op = 8'($urandom_range(255)); while (op == SYS_HALT);
                    send_byte(OPC_SYSCALL, chance(2));
                    send_byte(op, chance(4));
                end else begin
                    do op = 8'($urandom_range(255));
                    while (op inside {OPC_PUSH, OPC_ADD, OPC_SUB, OPC_PRINT,
                                      OPC_ALLOC, OPC_SYSCALL});
                    send_byte(op, chance(4));
                end
            end
        end
    endtask

    // Fills the stack to the brim with allocs from a base near the top of the
    // address space, so the bump pointer wraps, then tries one more alloc and one
    // more push, and prints the top few entries. A last alloc shows that the
    // dropped one left the pointer where it was.
    task automatic test_stack_overflow();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_byte(8'h00, 1'b1);
        write_bump_start(64'hFFFF_FFFF_FFFF_F000);
        while (depth_now < DEPTH) begin
            send_byte(OPC_ALLOC, 1'b0);
            send_operand(64'($urandom_range(4096)), 4, 0);
        end
        send_byte(OPC_ALLOC, 1'b0);
        send_operand(64'h0000_1234, 4, 0);
        send_byte(OPC_PUSH, 1'b0);
        send_operand(pick_word(), 8, 0);
        repeat (8) send_byte(OPC_PRINT, 1'b0);
        send_byte(OPC_ALLOC, 1'b0);
        send_operand(64'd0, 4, 0);
        send_byte(OPC_PRINT, 1'b1);
    endtask

    // The halt comes last of all: a halting syscall that also carries an end mark,
    // followed by bytes that the halted unit must swallow without a word.
    task automatic test_halt();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_byte(8'h00, 1'b1);
        halt_enabled = 1'b1;
        send_byte(OPC_SYSCALL, 1'b0);
        send_byte(SYS_HALT, 1'b1);
        send_byte(OPC_PRINT, 1'b1);
        send_byte(OPC_PUSH, 1'b0);
        send_byte(OPC_SYSCALL, 1'b1);
    endtask

    initial begin
        reset_machine();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_ops();
        // Three random phases: sender idling less than the receiver, then the
        // reverse, then both running flat out, which the overflow and halt tests
        // keep. The bump pointer start moves from all ones through a random value
        // to zero.
        test_random_programs(30, 46, '1, 80);
        test_random_programs(46, 30, {$urandom, $urandom}, 80);
        test_random_programs(0, 0, 64'd0, 80);
        test_stack_overflow();
        test_halt();
        wait_idle();
        // Anything still owed at this point never arrived.
        mismatches += awaited.size();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Safety net against a hung handshake; far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/bsm_pkg.sv
rtl/bsm_ram.sv
rtl/bytecode_stack_machine_unit.sv
tb/sv/tb_top.sv
